### rtl/frmdec_pkg.sv
// Shared constants for the framed decimal receiver.
package frmdec_pkg;

   // Framing and body characters.
   localparam logic [7:0] CH_START = 8'h40;
   localparam logic [7:0] CH_END   = 8'h24;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int MAX_BODY_CHARS_DEFAULT = 5;

   // Field widths.
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 3;
   localparam int MAG_W   = 17;
   localparam int QUOT_W  = 14;
   localparam int WHOLE_W = 15;
   localparam int DIGIT_W = 4;

   // Largest magnitude the accumulator can hold; it saturates here.
   localparam logic [MAG_W-1:0] ACC_MAX = 17'd131071;

   // ceil(2^20 / 10): floor(m * RECIP_TEN / 2^20) equals m / 10 for every m below 2^18.
   localparam int RECIP_SHIFT = 20;
   localparam logic [MAG_W-1:0] RECIP_TEN = 17'd104858;

endpackage

### rtl/framed_decimal_receiver.sv
// Framed ASCII decimal receiver: parses '@' ... '$' frames into a value and its tenths.
//
// The block takes one received byte per cycle while req_stall is low, and gives one result
// for each frame closed by a valid '$'. The '$' is held in the input stage, where it is parsed
// and the frame state is updated as it leaves; the divide stage then holds the quotient, and
// the result stage finishes the divide by ten. The divide uses a reciprocal multiply, and the
// remainder is formed in the result stage. The frame state is updated once per byte, so the
// sustained rate is one byte per clock while nothing stalls. The input is stalled only
// when every stage holds an item and the result side is stalling. A frame is '@', then
// up to MAX_BODY_CHARS characters from the digits and '-', then '$'. The body is scanned
// as a signed decimal. If the body holds no digits, the previous value is reported again
// with rsp_number_found low.
module framed_decimal_receiver #(
   parameter int MAX_BODY_CHARS = frmdec_pkg::MAX_BODY_CHARS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic        [frmdec_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [frmdec_pkg::WHOLE_W-1:0]     rsp_whole_part,
   output logic        [frmdec_pkg::DIGIT_W-1:0]     rsp_tenths_digit,
   output logic                                      rsp_number_found
);

   typedef enum logic [1:0] {
      PH_SIGN,
      PH_MINUS,
      PH_DIGITS,
      PH_STOPPED
   } phase_type;

   localparam int SUM_W  = frmdec_pkg::MAG_W + 4;
   localparam int PROD_W = 2 * frmdec_pkg::MAG_W;

   // Pipeline valids and moves.
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_move, b_move, a_move;

   // Input stage.
   logic [frmdec_pkg::BYTE_W-1:0] a_byte_ff, a_byte_in;

   // Frame state.
   logic                              in_frame_ff, in_frame_in;
   logic [frmdec_pkg::COUNT_W-1:0]    body_count_ff, body_count_in;
   logic [frmdec_pkg::MAG_W-1:0]      acc_ff, acc_in;
   logic                              minus_ff, minus_in;
   phase_type                         phase_ff, phase_in;
   logic [frmdec_pkg::MAG_W-1:0]      held_mag_ff, held_mag_in;
   logic                              held_neg_ff, held_neg_in;

   // Divide stage.
   logic [frmdec_pkg::QUOT_W-1:0]     b_quot_ff, b_quot_in;
   logic [frmdec_pkg::MAG_W-1:0]      b_mag_ff, b_mag_in;
   logic                              b_neg_ff, b_neg_in;
   logic                              b_found_ff, b_found_in;

   // Result stage.
   logic signed [frmdec_pkg::WHOLE_W-1:0] rsp_whole_ff, rsp_whole_in;
   logic [frmdec_pkg::DIGIT_W-1:0]        rsp_digit_ff, rsp_digit_in;
   logic                                  rsp_found_ff, rsp_found_in;

   // Parse signals.
   logic                              is_digit, is_start, is_end, is_minus;
   logic [3:0]                        digit_val;
   logic [SUM_W-1:0]                  acc_next_sum;
   logic [frmdec_pkg::MAG_W-1:0]      acc_step;
   logic                              emit, found;
   logic [PROD_W-1:0]                 quot_prod;
   logic [frmdec_pkg::MAG_W-1:0]      ten_quot, rem_full;
   logic [frmdec_pkg::WHOLE_W-1:0]    quot_ext;

   // A stage loads when it is empty or its contents move on in the same cycle.
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign b_move    = !b_valid_ff || out_move;
   assign a_move    = !a_valid_ff || b_move;
   assign req_stall = !a_move;

   assign is_start  = (a_byte_ff == frmdec_pkg::CH_START);
   assign is_end    = (a_byte_ff == frmdec_pkg::CH_END);
   assign is_minus  = (a_byte_ff == frmdec_pkg::CH_MINUS);
   assign is_digit  = (a_byte_ff >= frmdec_pkg::CH_ZERO) && (a_byte_ff <= frmdec_pkg::CH_NINE);
   assign digit_val = 4'(a_byte_ff - frmdec_pkg::CH_ZERO);

   // Multiply by ten as two shifts, then saturate.
   assign acc_next_sum = SUM_W'({acc_ff, 3'b000}) + SUM_W'({acc_ff, 1'b0}) + SUM_W'(digit_val);
   assign acc_step     = (acc_next_sum > SUM_W'(frmdec_pkg::ACC_MAX))
                         ? frmdec_pkg::ACC_MAX
                         : acc_next_sum[frmdec_pkg::MAG_W-1:0];

   always_comb begin
      in_frame_in   = in_frame_ff;
      body_count_in = body_count_ff;
      acc_in        = acc_ff;
      minus_in      = minus_ff;
      phase_in      = phase_ff;
      held_mag_in   = held_mag_ff;
      held_neg_in   = held_neg_ff;
      emit          = 1'b0;
      found         = (phase_ff == PH_DIGITS) || (phase_ff == PH_STOPPED);
      // The byte is consumed only in the cycle it leaves the input stage.
      if (a_valid_ff && a_move) begin
         priority if (is_start) begin
            in_frame_in   = 1'b1;
            body_count_in = '0;
            acc_in        = '0;
            minus_in      = 1'b0;
            phase_in      = PH_SIGN;
         end else if (!(is_end || is_minus || is_digit)) begin
            in_frame_in = 1'b0;
         end else if (!in_frame_ff) begin
            in_frame_in = 1'b0;
         end else if (!is_end) begin
            if (body_count_ff < frmdec_pkg::COUNT_W'(MAX_BODY_CHARS)) begin
               body_count_in = body_count_ff + 1'b1;
               unique case (phase_ff)
                  PH_SIGN: begin
                     if (is_digit) begin
                        acc_in   = frmdec_pkg::MAG_W'(digit_val);
                        phase_in = PH_DIGITS;
                     end else begin
                        minus_in = 1'b1;
                        phase_in = PH_MINUS;
                     end
                  end
                  PH_MINUS: begin
                     // A second minus fails the scan; the phase stays put with the sign cleared.
                     if (minus_ff) begin
                        if (is_digit) begin
                           acc_in   = frmdec_pkg::MAG_W'(digit_val);
                           phase_in = PH_DIGITS;
                        end else begin
                           minus_in = 1'b0;
                        end
                     end
                  end
                  PH_DIGITS: begin
                     if (is_digit) begin
                        acc_in = acc_step;
                     end else begin
                        phase_in = PH_STOPPED;
                     end
                  end
                  PH_STOPPED: begin
                     phase_in = PH_STOPPED;
                  end
               endcase
            end else begin
               in_frame_in = 1'b0;
            end
         end else if (body_count_ff != '0) begin
            in_frame_in = 1'b0;
            emit        = 1'b1;
            if (found) begin
               held_mag_in = acc_ff;
               held_neg_in = minus_ff;
            end
         end else begin
            // An end byte after an empty body leaves the frame open.
         end
      end
   end

   assign a_valid_in = a_move ? req_valid : a_valid_ff;
   assign a_byte_in  = a_move ? req_rx_byte : a_byte_ff;

   // Divide stage: quotient by reciprocal multiply.
   assign quot_prod  = PROD_W'(held_mag_in) * PROD_W'(frmdec_pkg::RECIP_TEN);
   assign b_valid_in = b_move ? (a_valid_ff && emit) : b_valid_ff;
   assign b_quot_in  = b_move ? quot_prod[frmdec_pkg::RECIP_SHIFT +: frmdec_pkg::QUOT_W]
                              : b_quot_ff;
   assign b_mag_in   = b_move ? held_mag_in : b_mag_ff;
   assign b_neg_in   = b_move ? held_neg_in : b_neg_ff;
   assign b_found_in = b_move ? found : b_found_ff;

   // Result stage: remainder and signed quotient.
   assign ten_quot     = frmdec_pkg::MAG_W'({b_quot_ff, 3'b000}) +
                         frmdec_pkg::MAG_W'({b_quot_ff, 1'b0});
   assign rem_full     = b_mag_ff - ten_quot;
   assign quot_ext     = frmdec_pkg::WHOLE_W'(b_quot_ff);
   assign rsp_valid_in = out_move ? b_valid_ff : rsp_valid_ff;
   assign rsp_whole_in = out_move ? (b_neg_ff ? $signed(-quot_ext) : $signed(quot_ext))
                                  : rsp_whole_ff;
   assign rsp_digit_in = out_move ? rem_full[frmdec_pkg::DIGIT_W-1:0] : rsp_digit_ff;
   assign rsp_found_in = out_move ? b_found_ff : rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_frame_ff   <= 1'b0;
         body_count_ff <= '0;
         acc_ff        <= '0;
         minus_ff      <= 1'b0;
         phase_ff      <= PH_SIGN;
         held_mag_ff   <= '0;
         held_neg_ff   <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         in_frame_ff   <= in_frame_in;
         body_count_ff <= body_count_in;
         acc_ff        <= acc_in;
         minus_ff      <= minus_in;
         phase_ff      <= phase_in;
         held_mag_ff   <= held_mag_in;
         held_neg_ff   <= held_neg_in;
      end
      a_byte_ff    <= a_byte_in;
      b_quot_ff    <= b_quot_in;
      b_mag_ff     <= b_mag_in;
      b_neg_ff     <= b_neg_in;
      b_found_ff   <= b_found_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_whole_part   = rsp_whole_ff;
   assign rsp_tenths_digit = rsp_digit_ff;
   assign rsp_number_found = rsp_found_ff;

   // The remainder from the reciprocal divide is always a single decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tenths_digit <= frmdec_pkg::DIGIT_W'(9)))
      else $error("tenths digit out of range");

   // The body count never passes the frame limit.
   assert property (@(posedge clock) disable iff (reset)
      body_count_ff <= frmdec_pkg::COUNT_W'(MAX_BODY_CHARS))
      else $error("body count beyond limit");

   // A new result only follows a filled divide stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_valid_ff))
      else $error("result without divide stage item");

   // An input stage that holds a byte stalls the request side only when the divide and result stages are full too.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

endmodule

### tb/tb_framed_decimal_receiver.sv
// Self-checking testbench for the framed decimal receiver, with random frames and back-pressure.
`timescale 1ns / 1ps

module tb_framed_decimal_receiver;

   localparam int MAX_BODY    = frmdec_pkg::MAX_BODY_CHARS_DEFAULT;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 16;

   // Scan progress through the frame body.
   localparam logic [1:0] SCAN_SIGN        = 2'd0;
   localparam logic [1:0] SCAN_AFTER_MINUS = 2'd1;
   localparam logic [1:0] SCAN_DIGITS      = 2'd2;
   localparam logic [1:0] SCAN_STOPPED     = 2'd3;

   typedef logic        [frmdec_pkg::BYTE_W-1:0]  byte_type;
   typedef logic signed [frmdec_pkg::WHOLE_W-1:0] whole_type;
   typedef logic        [frmdec_pkg::DIGIT_W-1:0] tenths_type;

   typedef struct {
      whole_type  whole;
      tenths_type tenths;
      logic       found;
   } reading_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   byte_type   req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   whole_type  rsp_whole_part;
   tenths_type rsp_tenths_digit;
   logic       rsp_number_found;

   byte_type    pending_bytes[$];
   reading_type expected_readings[$];
   reading_type due;

   // Parser state mirrored from the block.
   bit         frame_open;
   int         body_len;
   int         digit_mag;
   bit         leading_minus;
   logic [1:0] scan_state;
   int         held_reading;

   bit quiet_tail;
   bit hold_req;
   int gap_left, send_calm;
   int stall_left, recv_calm, hold_left;
   int cycle_count, error_count;
   int bytes_sent, results_seen, results_with_digits, input_stall_cycles;

   framed_decimal_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_whole_part   (rsp_whole_part),
      .rsp_tenths_digit (rsp_tenths_digit),
      .rsp_number_found (rsp_number_found)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advances the mirrored parser by one byte and queues the reading a valid end byte yields.
   function automatic void parse_byte(input byte_type c);
      bit          is_digit;
      int          d;
      int          rem;
      reading_type r;
      is_digit = (c >= frmdec_pkg::CH_ZERO) && (c <= frmdec_pkg::CH_NINE);
      d = int'(c) - int'(frmdec_pkg::CH_ZERO);
      if (c == frmdec_pkg::CH_START) begin
         frame_open = 1'b1;
         body_len = 0;
         digit_mag = 0;
         leading_minus = 1'b0;
         scan_state = SCAN_SIGN;
      end else if (!(c == frmdec_pkg::CH_END || c == frmdec_pkg::CH_MINUS || is_digit)) begin
         frame_open = 1'b0;
      end else if (!frame_open) begin
         // Body and end bytes outside a frame are dropped.
      end else if (c != frmdec_pkg::CH_END) begin
         if (body_len < MAX_BODY) begin
            body_len = (body_len + 1) & 7;
            case (scan_state)
               SCAN_SIGN: begin
                  if (is_digit) begin
                     digit_mag = d;
                     scan_state = SCAN_DIGITS;
                  end else begin
                     leading_minus = 1'b1;
                     scan_state = SCAN_AFTER_MINUS;
                  end
               end
               SCAN_AFTER_MINUS: begin
                  // A second minus kills the scan for the rest of the frame.
                  if (leading_minus) begin
                     if (is_digit) begin
                        digit_mag = d;
                        scan_state = SCAN_DIGITS;
                     end else begin
                        leading_minus = 1'b0;
                     end
                  end
               end
               SCAN_DIGITS: begin
                  if (!is_digit) begin
                     scan_state = SCAN_STOPPED;
                  end else if (digit_mag > (int'(frmdec_pkg::ACC_MAX) - d) / 10) begin
                     digit_mag = int'(frmdec_pkg::ACC_MAX);
                  end else begin
                     digit_mag = digit_mag * 10 + d;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            frame_open = 1'b0;
         end
      end else if (body_len != 0) begin
         frame_open = 1'b0;
         r.found = (scan_state == SCAN_DIGITS) || (scan_state == SCAN_STOPPED);
         if (r.found) held_reading = leading_minus ? -digit_mag : digit_mag;
         rem = held_reading % 10;
         r.whole = whole_type'(held_reading / 10);
         r.tenths = tenths_type'((rem < 0) ? -rem : rem);
         expected_readings.push_back(r);
      end
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   // Queues random traffic until about the given number of frame bytes have been added.
   task automatic queue_random(input int target, input bit frames_only);
      int added;
      int pick;
      int len;
      added = 0;
      while (added < target) begin
         pick = frames_only ? 0 : $urandom_range(0, 99);
         if (pick < 85) begin
            pending_bytes.push_back(frmdec_pkg::CH_START);
            added++;
            if (pick >= 70) begin
               // Broken frame: up to four body bytes, then a random byte or a restart.
               len = $urandom_range(0, 4);
               for (int i = 0; i < len; i++) begin
                  pending_bytes.push_back(($urandom_range(0, 3) == 0)
                     ? frmdec_pkg::CH_MINUS
                     : byte_type'(frmdec_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
               pending_bytes.push_back($urandom_range(0, 1)
                  ? frmdec_pkg::CH_START
                  : byte_type'($urandom_range(0, 255)));
               added += len + 1;
            end
            if ($urandom_range(0, 9) == 0) begin
               pending_bytes.push_back(frmdec_pkg::CH_END);
               added++;
            end
            len = ($urandom_range(0, 19) == 0) ? MAX_BODY + 1 : $urandom_range(1, MAX_BODY);
            for (int i = 0; i < len; i++) begin
               if ((i == 0 && $urandom_range(0, 3) == 0) || $urandom_range(0, 11) == 0)
                  pending_bytes.push_back(frmdec_pkg::CH_MINUS);
               else
                  pending_bytes.push_back(byte_type'(frmdec_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            pending_bytes.push_back(frmdec_pkg::CH_END);
            added += len + 1;
         end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) pending_bytes.push_back(byte_type'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   // Sender: offers queued bytes, with random gaps and calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         send_calm = 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 && !quiet_tail) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!quiet_tail && send_calm == 0 && $urandom_range(0, 6) == 0) begin
               req_valid <= 1'b0;
               gap_left = $urandom_range(0, 11);
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               if (send_calm > 0) send_calm--;
               else if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(20, 80);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transfer and drives random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         recv_calm = 0;
         hold_left = 0;
      end else begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_number_found) results_with_digits++;
            if (expected_readings.size() == 0) begin
               $error("unexpected result: whole_part %0d, tenths_digit %0d, number_found %0b",
                      rsp_whole_part, rsp_tenths_digit, rsp_number_found);
               error_count++;
            end else begin
               due = expected_readings.pop_front();
               if (rsp_whole_part !== due.whole) begin
                  $error("whole_part: expected %0d, actual %0d", due.whole, rsp_whole_part);
                  error_count++;
               end
               if (rsp_tenths_digit !== due.tenths) begin
                  $error("tenths_digit: expected %0d, actual %0d", due.tenths, rsp_tenths_digit);
                  error_count++;
               end
               if (rsp_number_found !== due.found) begin
                  $error("number_found: expected %0b, actual %0b", due.found, rsp_number_found);
                  error_count++;
               end
            end
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0 && !quiet_tail) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 11);
         end else begin
            rsp_stall <= 1'b0;
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 80);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      // Outside-frame bytes, a foreign byte closing a frame, an empty body, a killed scan,
      // a restart inside a frame, and both magnitude extremes.
      pending_bytes.push_back(8'hFF);
      push_text("$@7");
      pending_bytes.push_back(8'h00);
      push_text("-$@-@-9999$@$--3$@99999$");
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      queue_random(500, 1'b0);
      wait_drained();

      // The receiver holds off while whole frames keep arriving, so the block backs up.
      @(negedge clock);
      hold_req = 1'b1;
      queue_random(150, 1'b1);
      queue_random(350, 1'b0);
      wait_drained();

      quiet_tail = 1'b1;
      queue_random(200, 1'b0);
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d bytes; checked %0d results, %0d of them with parsed digits.",
               bytes_sent, results_seen, results_with_digits);
      $display("Input was held off by the block for %0d cycles.", input_stall_cycles);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
